### rtl/fut_pkg.sv
// ----------------------------------------------------------------------------
// fut_pkg
// Shared types and constants of the filter usage timer with levels.
// ----------------------------------------------------------------------------
package fut_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned LimitW    = 31;
  localparam int unsigned IntervalW = 20;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned RedW      = 2;
  localparam int unsigned SubMsW    = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  // Session clock: ms ticks per whole second
  localparam logic [SubMsW-1:0] TicksPerSecond = SubMsW'(1000);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxOperating   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxReplacement = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSaveInterval   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInitialTime    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInitialLevel   = 3'd4;

  // Register reset values
  localparam logic [LimitW-1:0]    RstMaxOperating   = LimitW'(28800);
  localparam logic [LimitW-1:0]    RstMaxReplacement = LimitW'(1800);
  localparam logic [IntervalW-1:0] RstSaveInterval   = IntervalW'(30000);
  localparam logic [TimeW-1:0]     RstInitialTime    = '0;
  localparam logic [LevelW-1:0]    RstInitialLevel   = '0;

  // Level codes
  localparam logic [LevelW-1:0] LvlOperating   = 2'd0;
  localparam logic [LevelW-1:0] LvlReplacement = 2'd1;
  localparam logic [LevelW-1:0] LvlBlocked     = 2'd2;
  localparam logic [LevelW-1:0] LvlInvalid     = 2'd3;

  // Red indicator modes
  localparam logic [RedW-1:0] RedOff    = 2'd0;
  localparam logic [RedW-1:0] RedSteady = 2'd1;
  localparam logic [RedW-1:0] RedBlink  = 2'd2;

  typedef struct packed {
    logic [LimitW-1:0]    max_operating_s;
    logic [LimitW-1:0]    max_replacement_s;
    logic [IntervalW-1:0] save_interval_ms;
  } fut_cfg_t;

  typedef struct packed {
    logic                 session_active;
    logic [SubMsW-1:0]    session_subsecond_ms;
    logic [TimeW-1:0]     session_seconds;
    logic [TimeW-1:0]     base_seconds;
    logic [TimeW-1:0]     persisted_seconds;
    logic [LevelW-1:0]    level;
    logic                 long_beep_armed;
    logic [IntervalW-1:0] ms_since_save;
  } fut_state_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              green_lit;
    logic [RedW-1:0]   red_mode;
    logic              beep_blink;
    logic              beep_start;
    logic              beep_long;
    logic              time_write;
    logic [TimeW-1:0]  time_write_value;
  } fut_result_t;

  // 32-bit add that sticks at all ones
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

endpackage

### rtl/fut_step.sv
// ----------------------------------------------------------------------------
// fut_step
// One-tick update: next meter state and the result of one tick request.
// ----------------------------------------------------------------------------
module fut_step (
  input  fut_pkg::fut_cfg_t    cfg_i,
  input  fut_pkg::fut_state_t  state_i,
  input  logic                 button_pressed_i,
  output fut_pkg::fut_state_t  state_o,
  output fut_pkg::fut_result_t result_o
);
  import fut_pkg::*;

  logic [TimeW-1:0]     limit_sum;
  logic [TimeW-1:0]     total;
  logic [SubMsW-1:0]    sub_inc;
  logic [IntervalW-1:0] mss_inc;
  fut_state_t           s;
  fut_result_t          r;

  // Both limits are 31 bits wide, so this sum cannot overflow 32 bits
  assign limit_sum = {1'b0, cfg_i.max_operating_s} + {1'b0, cfg_i.max_replacement_s};

  always_comb begin
    s = state_i;
    r = '0;
    total = '0;
    sub_inc = state_i.session_subsecond_ms + SubMsW'(1);
    mss_inc = state_i.ms_since_save + IntervalW'(1);

    // session clock
    if (state_i.session_active) begin
      if (sub_inc >= TicksPerSecond) begin
        s.session_subsecond_ms = '0;
        s.session_seconds      = sat_add(state_i.session_seconds, TimeW'(1));
      end else begin
        s.session_subsecond_ms = sub_inc;
      end
    end

    // save spacing counter, clamped to the interval
    if (state_i.ms_since_save < cfg_i.save_interval_ms) begin
      s.ms_since_save = mss_inc;
    end else begin
      s.ms_since_save = cfg_i.save_interval_ms;
    end

    if (button_pressed_i) begin
      if (!state_i.session_active) begin
        s.session_active       = 1'b1;
        s.session_subsecond_ms = '0;
        s.session_seconds      = '0;
        s.base_seconds         = state_i.persisted_seconds;
        s.long_beep_armed      = 1'b1;
        r.beep_start           = 1'b1;
      end
      total = sat_add(s.base_seconds, s.session_seconds);
      if (s.ms_since_save >= cfg_i.save_interval_ms) begin
        r.time_write        = 1'b1;
        r.time_write_value  = total;
        s.persisted_seconds = total;
        s.ms_since_save     = '0;
      end
      if (total < {1'b0, cfg_i.max_operating_s}) begin
        s.level = LvlOperating;
      end else if (total < limit_sum) begin
        s.level = LvlReplacement;
      end else begin
        s.level = LvlBlocked;
      end
    end else if (state_i.session_active) begin
      s.session_active = 1'b0;
      s.base_seconds   = sat_add(state_i.base_seconds, s.session_seconds);
      r.time_write     = 1'b1;
      if (state_i.level == LvlReplacement) begin
        s.level            = LvlBlocked;
        r.time_write_value = limit_sum;
      end else begin
        r.time_write_value = s.base_seconds;
      end
      s.persisted_seconds = r.time_write_value;
    end

    // indication
    unique case (s.level)
      LvlOperating: begin
        r.green_lit = 1'b1;
      end
      LvlReplacement: begin
        r.red_mode   = RedBlink;
        r.beep_blink = 1'b1;
      end
      LvlBlocked: begin
        r.red_mode = RedSteady;
        if (s.long_beep_armed) begin
          s.long_beep_armed = 1'b0;
          r.beep_long       = 1'b1;
        end
      end
      default: begin
        // invalid level: all indication off, long beep stays armed
      end
    endcase
    r.level = s.level;
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

### rtl/filter_usage_timer_levels.sv
// ----------------------------------------------------------------------------
// filter_usage_timer_levels
// Filter usage meter with operating, replacement and blocked levels.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per millisecond tick on the input channel
//   (in_valid_i / in_ready_o) carrying the debounced button level.
//   Each accepted request yields exactly one result on the output channel
//   (out_valid_o / out_ready_i): level, indicator and beeper modes, the
//   start and long beep pulses and a persisted-time write strobe with value.
//   Timing: the result is registered and valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken; the update is a single combinational
//   pass between the meter state registers and the result register.
//   Stall: while a result waits and out_ready_i is low, in_ready_o is low;
//   when the result is taken, a new request is accepted in the same cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 max operating s, 1 max replacement s, 2 save interval ms,
//   3 initial time s, 4 initial level). Writing the initial time loads the
//   base and persisted time; writing the initial level loads the level.
//   Other indexes are ignored. Write only while no request is in flight.
//   Reset (rst_ni low, asynchronous): configuration and state registers return to their defaults,
//   no session is active, and the output channel is empty.
// ----------------------------------------------------------------------------
module filter_usage_timer_levels (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          button_pressed_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fut_pkg::LevelW-1:0]    level_o,
  output logic                          green_lit_o,
  output logic [fut_pkg::RedW-1:0]      red_mode_o,
  output logic                          beep_blink_o,
  output logic                          beep_start_o,
  output logic                          beep_long_o,
  output logic                          time_write_o,
  output logic [fut_pkg::TimeW-1:0]     time_write_value_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [fut_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fut_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fut_pkg::*;

  fut_cfg_t    cfg_q, cfg_d;
  fut_state_t  state_q, state_d, step_state;
  fut_result_t step_result;
  fut_result_t result_q;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;

  // Result register is free, or being emptied this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  fut_step u_step (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .button_pressed_i (button_pressed_i),
    .state_o          (step_state),
    .result_o         (step_result)
  );

  // Config writes and state update; the user must write only while idle, not enforced here
  always_comb begin
    cfg_d   = cfg_q;
    state_d = state_q;
    if (in_accept) begin
      state_d = step_state;
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMaxOperating:   cfg_d.max_operating_s   = cfg_wdata_i[LimitW-1:0];
        CfgMaxReplacement: cfg_d.max_replacement_s = cfg_wdata_i[LimitW-1:0];
        CfgSaveInterval:   cfg_d.save_interval_ms  = cfg_wdata_i[IntervalW-1:0];
        CfgInitialTime: begin
          state_d.base_seconds      = cfg_wdata_i[TimeW-1:0];
          state_d.persisted_seconds = cfg_wdata_i[TimeW-1:0];
        end
        CfgInitialLevel:   state_d.level = cfg_wdata_i[LevelW-1:0];
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_operating_s       <= RstMaxOperating;
      cfg_q.max_replacement_s     <= RstMaxReplacement;
      cfg_q.save_interval_ms      <= RstSaveInterval;
      state_q.session_active       <= 1'b0;
      state_q.session_subsecond_ms <= '0;
      state_q.session_seconds      <= '0;
      state_q.base_seconds         <= RstInitialTime;
      state_q.persisted_seconds    <= RstInitialTime;
      state_q.level                <= RstInitialLevel;
      state_q.long_beep_armed      <= 1'b0;
      state_q.ms_since_save        <= '0;
      out_valid_q                  <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign level_o            = result_q.level;
  assign green_lit_o        = result_q.green_lit;
  assign red_mode_o         = result_q.red_mode;
  assign beep_blink_o       = result_q.beep_blink;
  assign beep_start_o       = result_q.beep_start;
  assign beep_long_o        = result_q.beep_long;
  assign time_write_o       = result_q.time_write;
  assign time_write_value_o = result_q.time_write_value;

endmodule

### bench/tb_filter_usage_timer_levels.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_filter_usage_timer_levels
// Self-checking bench for the filter usage meter. A short scripted run walks
// the level codes, the saturating sums, the save interval edges and the
// release from replacement. Randomized press sessions follow under changing
// register settings. Both handshakes idle and stall at random. Every result
// is checked field by field against an in-bench model of the meter or a hand-typed result.
// ----------------------------------------------------------------------------
module tb_filter_usage_timer_levels;
  import fut_pkg::*;

  localparam int unsigned WatchdogLimit  = 5000;  // quiet cycles before giving up
  localparam int unsigned SinkHoldCycles = 200;   // one long output back-pressure
  localparam int unsigned SinkHoldAfter  = 400;   // results taken before that hold
  localparam int unsigned RandomTicks    = 1330;
  localparam int unsigned PrintCap       = 40;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                button_pressed_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [LevelW-1:0]   level_o;
  logic                green_lit_o;
  logic [RedW-1:0]     red_mode_o;
  logic                beep_blink_o;
  logic                beep_start_o;
  logic                beep_long_o;
  logic                time_write_o;
  logic [TimeW-1:0]    time_write_value_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  always #5 clk_i = ~clk_i;

  filter_usage_timer_levels dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .button_pressed_i   (button_pressed_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .level_o            (level_o),
    .green_lit_o        (green_lit_o),
    .red_mode_o         (red_mode_o),
    .beep_blink_o       (beep_blink_o),
    .beep_start_o       (beep_start_o),
    .beep_long_o        (beep_long_o),
    .time_write_o       (time_write_o),
    .time_write_value_o (time_write_value_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Meter model: register copies and session state
  // --------------------------------------------------------------------------
  logic [LimitW-1:0]    op_limit_s;
  logic [LimitW-1:0]    repl_limit_s;
  logic [IntervalW-1:0] save_gap_ms;
  logic                 sess_on;
  logic [SubMsW-1:0]    sess_ms;
  logic [TimeW-1:0]     sess_secs;
  logic [TimeW-1:0]     base_secs;
  logic [TimeW-1:0]     stored_secs;
  logic [LevelW-1:0]    meter_level;
  logic                 long_armed;
  logic [IntervalW-1:0] ms_unsaved;

  fut_result_t results_due[$];   // predicted results, oldest first
  int unsigned error_count   = 0;
  int unsigned results_taken = 0;
  int unsigned ticks_sent    = 0;
  bit          source_steady = 1'b0;  // no input gaps in this phase

  // Scripted opening: register writes and ticks, some with a hand-typed result
  typedef enum logic {RowTick, RowWrite} row_kind_e;
  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                press;
    bit                  typed;
    fut_result_t         golden;
  } script_row_t;
  script_row_t script_rows[$];

  function automatic logic [TimeW-1:0] add_clamped(input logic [TimeW-1:0] a,
                                                   input logic [TimeW-1:0] b);
    if (a > ~b) return '1;
    return a + b;
  endfunction

  task automatic meter_reset();
    op_limit_s   = RstMaxOperating;
    repl_limit_s = RstMaxReplacement;
    save_gap_ms  = RstSaveInterval;
    sess_on      = 1'b0;
    sess_ms      = '0;
    sess_secs    = '0;
    base_secs    = RstInitialTime;
    stored_secs  = RstInitialTime;
    meter_level  = RstInitialLevel;
    long_armed   = 1'b0;
    ms_unsaved   = '0;
  endtask

  task automatic apply_setting(input logic [CfgIdxW-1:0] idx,
                               input logic [CfgDataW-1:0] data);
    case (idx)
      CfgMaxOperating:   op_limit_s   = data[LimitW-1:0];
      CfgMaxReplacement: repl_limit_s = data[LimitW-1:0];
      CfgSaveInterval:   save_gap_ms  = data[IntervalW-1:0];
      CfgInitialTime: begin
        base_secs   = data[TimeW-1:0];
        stored_secs = data[TimeW-1:0];
      end
      CfgInitialLevel:   meter_level  = data[LevelW-1:0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // One millisecond tick of the meter; returns the indication it shows
  function automatic fut_result_t meter_tick(input logic press);
    fut_result_t      r;
    logic [TimeW-1:0] limit_sum;
    logic [TimeW-1:0] total;
    r = '0;
    limit_sum = add_clamped(TimeW'(op_limit_s), TimeW'(repl_limit_s));
    if (sess_on) begin
      sess_ms = sess_ms + 1'b1;
      if (sess_ms >= TicksPerSecond) begin
        sess_ms   = '0;
        sess_secs = add_clamped(sess_secs, TimeW'(1));
      end
    end
    // save timer sticks at the interval; a lowered interval pulls it down
    if (ms_unsaved < save_gap_ms) ms_unsaved = ms_unsaved + 1'b1;
    if (ms_unsaved > save_gap_ms) ms_unsaved = save_gap_ms;

    if (press) begin
      if (!sess_on) begin
        sess_on      = 1'b1;
        sess_ms      = '0;
        sess_secs    = '0;
        r.beep_start = 1'b1;
        base_secs    = stored_secs;
        long_armed   = 1'b1;
      end
      total = add_clamped(base_secs, sess_secs);
      if (ms_unsaved >= save_gap_ms) begin
        r.time_write       = 1'b1;
        r.time_write_value = total;
        stored_secs        = total;
        ms_unsaved         = '0;
      end
      if (total < TimeW'(op_limit_s))  meter_level = LvlOperating;
      else if (total < limit_sum)      meter_level = LvlReplacement;
      else                             meter_level = LvlBlocked;
    end else if (sess_on) begin
      sess_on      = 1'b0;
      base_secs    = add_clamped(base_secs, sess_secs);
      r.time_write = 1'b1;
      // leaving replacement locks the meter at the full budget
      if (meter_level == LvlReplacement) begin
        meter_level        = LvlBlocked;
        r.time_write_value = limit_sum;
      end else begin
        r.time_write_value = base_secs;
      end
      stored_secs = r.time_write_value;
    end

    r.level = meter_level;
    case (meter_level)
      LvlOperating: r.green_lit = 1'b1;
      LvlReplacement: begin
        r.red_mode   = RedBlink;
        r.beep_blink = 1'b1;
      end
      LvlBlocked: begin
        r.red_mode = RedSteady;
        if (long_armed) begin
          long_armed  = 1'b0;
          r.beep_long = 1'b1;
        end
      end
      default: ;  // invalid level: everything dark, long beep stays armed
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [TimeW-1:0] got,
                               input logic [TimeW-1:0] want);
    error_count++;
    if (error_count <= PrintCap)
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(input fut_result_t want);
    if (level_o !== want.level)
      note_mismatch("level", TimeW'(level_o), TimeW'(want.level));
    if (green_lit_o !== want.green_lit)
      note_mismatch("green_lit", TimeW'(green_lit_o), TimeW'(want.green_lit));
    if (red_mode_o !== want.red_mode)
      note_mismatch("red_mode", TimeW'(red_mode_o), TimeW'(want.red_mode));
    if (beep_blink_o !== want.beep_blink)
      note_mismatch("beep_blink", TimeW'(beep_blink_o), TimeW'(want.beep_blink));
    if (beep_start_o !== want.beep_start)
      note_mismatch("beep_start", TimeW'(beep_start_o), TimeW'(want.beep_start));
    if (beep_long_o !== want.beep_long)
      note_mismatch("beep_long", TimeW'(beep_long_o), TimeW'(want.beep_long));
    if (time_write_o !== want.time_write)
      note_mismatch("time_write", TimeW'(time_write_o), TimeW'(want.time_write));
    if (time_write_value_o !== want.time_write_value)
      note_mismatch("time_write_value", time_write_value_o, want.time_write_value);
  endtask

  // results are taken on the rising edge, where both handshake signals are settled
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      results_taken++;
      if (results_due.size() == 0) note_mismatch("result with nothing pending", 1, 0);
      else check_result(results_due.pop_front());
    end
  end

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly back to back, often short gaps, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // top bit lies above the 31-bit register and must be dropped by the block
  function automatic logic [CfgDataW-1:0] pick_limit();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = 32'h7FFF_FFFF;
      2, 3:    v = $urandom_range(0, 6);
      default: v = $urandom();
    endcase
    v[CfgDataW-1] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_interval();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = 1;
      2:       v = $urandom_range(2, 20);
      3:       v = {IntervalW{1'b1}};
      default: v = $urandom_range(21, 200);
    endcase
    v[CfgDataW-1:IntervalW] = (CfgDataW-IntervalW)'($urandom());
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_time();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 8);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic fut_result_t typed_result(
      input logic [LevelW-1:0] lvl, input logic green, input logic [RedW-1:0] red,
      input logic blink, input logic start_pulse, input logic long_pulse,
      input logic wr, input logic [TimeW-1:0] wr_val);
    fut_result_t r;
    r.level            = lvl;
    r.green_lit        = green;
    r.red_mode         = red;
    r.beep_blink       = blink;
    r.beep_start       = start_pulse;
    r.beep_long        = long_pulse;
    r.time_write       = wr;
    r.time_write_value = wr_val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Drive on the falling edge, hold until accepted, predict on acceptance.
  task automatic send_tick(input logic press, input bit typed, input fut_result_t golden);
    int unsigned gap;
    fut_result_t predicted;
    gap = source_steady ? 0 : pick_pause();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    button_pressed_i <= press;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = meter_tick(press);
    results_due.push_back(typed ? golden : predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stop requesting and let every pending result come out; registers are
  // only touched once the block is empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_setting(idx, data);
    @(negedge clk_i);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    script_row_t row;
    row       = '{kind: RowWrite, default: '0};
    row.idx   = idx;
    row.data  = data;
    script_rows.push_back(row);
  endtask

  task automatic add_tick(input logic press, input bit typed, input fut_result_t golden);
    script_row_t row;
    row        = '{kind: RowTick, default: '0};
    row.press  = press;
    row.typed  = typed;
    row.golden = golden;
    script_rows.push_back(row);
  endtask

  task automatic build_script();
    // defaults after reset: idle, then a one-tick session
    add_tick(1'b0, 1, typed_result(LvlOperating, 1, RedOff, 0, 0, 0, 0, 0));
    add_tick(1'b1, 1, typed_result(LvlOperating, 1, RedOff, 0, 1, 0, 0, 0));
    add_tick(1'b0, 1, typed_result(LvlOperating, 1, RedOff, 0, 0, 0, 1, 0));
    // forced levels; long beep is still armed from that session
    add_write(CfgInitialLevel, LvlInvalid);
    add_tick(1'b0, 1, typed_result(LvlInvalid, 0, RedOff, 0, 0, 0, 0, 0));
    add_write(CfgInitialLevel, LvlReplacement);
    add_tick(1'b0, 1, typed_result(LvlReplacement, 0, RedBlink, 1, 0, 0, 0, 0));
    add_write(CfgInitialLevel, LvlBlocked);
    add_tick(1'b0, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 0, 1, 0, 0));
    add_tick(1'b0, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 0, 0, 0, 0));
    // widest limits, zero interval, time at all ones: saturated total every tick
    add_write(CfgMaxOperating, '1);
    add_write(CfgMaxReplacement, '1);
    add_write(CfgSaveInterval, '0);
    add_write(CfgInitialTime, '1);
    add_tick(1'b1, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 1, 1, 1, '1));
    add_tick(1'b1, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 0, 0, 1, '1));
    add_tick(1'b0, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 0, 0, 1, '1));
    // release out of replacement stores the limit sum and blocks
    add_write(CfgInitialTime, 5);
    add_write(CfgMaxOperating, 5);
    add_write(CfgMaxReplacement, 3);
    add_write(CfgSaveInterval, 1000);
    add_tick(1'b1, 1, typed_result(LvlReplacement, 0, RedBlink, 1, 1, 0, 0, 0));
    add_tick(1'b0, 1, typed_result(LvlBlocked, 0, RedSteady, 0, 0, 1, 1, 8));
    // zero limits, interval of one, press out of the invalid level
    add_write(CfgMaxOperating, 0);
    add_write(CfgMaxReplacement, 0);
    add_write(CfgInitialTime, 0);
    add_write(CfgSaveInterval, 1);
    add_write(CfgInitialLevel, LvlInvalid);
    add_write({CfgIdxW{1'b1}}, 32'hA5A5_5A5A);  // unmapped index
    add_tick(1'b1, 0, '0);
    add_tick(1'b1, 0, '0);
    add_tick(1'b0, 0, '0);
    add_tick(1'b1, 0, '0);
    add_write(CfgSaveInterval, '1);
    add_write(CfgInitialLevel, LvlOperating);
    add_tick(1'b1, 0, '0);
    add_tick(1'b0, 0, '0);
  endtask

  // New register set for a random phase. The long phase holds the button past
  // a whole second with limits set so the level moves during the press.
  task automatic shuffle_settings(input bit long_run);
    logic [TimeW-1:0] t;
    if (long_run) begin
      t = $urandom_range(0, 3);
      cfg_write(CfgInitialTime, t);
      if ($urandom_range(0, 1)) begin
        cfg_write(CfgMaxOperating, t + 1);
        cfg_write(CfgMaxReplacement, 0);
      end else begin
        cfg_write(CfgMaxOperating, t);
        cfg_write(CfgMaxReplacement, 1);
      end
      cfg_write(CfgSaveInterval, $urandom_range(100, 400));
      cfg_write(CfgInitialLevel, $urandom());
    end else begin
      cfg_write(CfgMaxOperating, pick_limit());
      cfg_write(CfgMaxReplacement, pick_limit());
      cfg_write(CfgSaveInterval, pick_interval());
      cfg_write(CfgInitialTime, pick_time());
      cfg_write(CfgInitialLevel, $urandom());
      if ($urandom_range(0, 2) == 0)
        cfg_write(CfgIdxW'($urandom_range(int'(CfgInitialLevel) + 1, (1 << CfgIdxW) - 1)),
                  $urandom());
    end
  endtask

  // Mostly press/release sessions of random length, some single random ticks
  task automatic run_sessions(input int unsigned n);
    int unsigned stop_at;
    int unsigned k;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(1'($urandom_range(0, 1)), 0, '0);
      end else begin
        k = $urandom_range(1, 40);
        repeat (k) send_tick(1'b1, 0, '0);
        k = $urandom_range(1, 6);
        repeat (k) send_tick(1'b0, 0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, free-running stretches, one long hold-off
  // while the source keeps requesting so the input side backs up.
  // --------------------------------------------------------------------------
  initial begin : sink
    int unsigned stall_left;
    int unsigned cycles;
    bit          steady_sink;
    bit          held;
    stall_left  = 0;
    cycles      = 0;
    steady_sink = 1'b0;
    held        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles % 128 == 0) steady_sink = ($urandom_range(0, 3) == 0);
      if (!held && results_taken >= SinkHoldAfter) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (SinkHoldCycles) @(negedge clk_i);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady_sink) stall_left = pick_pause();
      end
    end
  end

  // Ends the run if neither channel nor the register port moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    button_pressed_i = 1'b0;
    out_ready_i      = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_wdata_i      = '0;
    meter_reset();
    build_script();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script_rows[i]) begin
      if (script_rows[i].kind == RowWrite) begin
        wait_drained();
        cfg_write(script_rows[i].idx, script_rows[i].data);
      end else begin
        send_tick(script_rows[i].press, script_rows[i].typed, script_rows[i].golden);
      end
    end

    // random phases; the third one is the long hold past a second
    target = ticks_sent + RandomTicks;
    phase  = 0;
    while (ticks_sent < target) begin
      wait_drained();
      source_steady = ($urandom_range(0, 3) == 0);
      shuffle_settings(phase == 2);
      if (phase == 2) begin
        repeat ($urandom_range(1000, 1080)) send_tick(1'b1, 0, '0);
        repeat (3) send_tick(1'b0, 0, '0);
      end else begin
        run_sessions($urandom_range(40, 80));
      end
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
